// ===== rtl/modbus_rtu_frame_classifier_top_defines.svh =====
// Assertion macros for the frame classifier RTL, included by mrfc_fifo.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef MODBUS_RTU_FRAME_CLASSIFIER_TOP_DEFINES_SVH
`define MODBUS_RTU_FRAME_CLASSIFIER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define MRFC_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define MRFC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define MRFC_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define MRFC_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// ===== rtl/mrfc_pkg.sv =====
// Types, constants and the CRC-16 byte update shared by the frame classifier.
// No dependencies.
package mrfc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FUNC_WRITE_SINGLE  = 8'h06;

    localparam int WATCH_MAX   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int HDR_BYTES   = 6;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SLAVE_ADDR = 3'd0;
    localparam logic [2:0] CFG_WATCH_A    = 3'd1;
    localparam logic [2:0] CFG_WATCH_B    = 3'd2;
    localparam logic [2:0] CFG_WATCH_C    = 3'd3;
    localparam logic [2:0] CFG_WATCH_D    = 3'd4;
    localparam logic [2:0] CFG_POLL_START = 3'd5;
    localparam logic [2:0] CFG_POLL_COUNT = 3'd6;

    localparam logic [7:0]  RST_SLAVE_ADDR = 8'd1;
    localparam logic [15:0] RST_WATCH_A    = 16'd3999;
    localparam logic [15:0] RST_WATCH_B    = 16'd1999;
    localparam logic [15:0] RST_WATCH_C    = 16'd2010;
    localparam logic [15:0] RST_WATCH_D    = 16'd2015;
    localparam logic [15:0] RST_POLL_START = 16'd2099;
    localparam logic [6:0]  RST_POLL_COUNT = 7'd40;

    typedef enum logic [2:0] {
        CLASS_OTHER    = 3'd0,
        CLASS_WATCHED  = 3'd1,
        CLASS_POLL_REQ = 3'd2,
        CLASS_POLL_RSP = 3'd3,
        CLASS_BAD_CRC  = 3'd4,
        CLASS_SHORT    = 3'd5,
        CLASS_OVERFLOW = 3'd6
    } class_t;

    typedef struct packed {
        logic [7:0]                     slave_addr;
        logic [WATCH_MAX-1:0][15:0]     watch_reg;   // index 0 is slot a
        logic [15:0]                    poll_start;
        logic [6:0]                     poll_count;
    } cfg_t;

    // Summary of one finished frame, handed from the front end to the back end.
    typedef struct packed {
        logic                           overflow;
        logic                           too_short;
        logic [8:0]                     length;
        logic [15:0]                    crc;
        logic [15:0]                    rx_crc;
        logic [HDR_BYTES-1:0][7:0]      hdr;
    } frame_rec_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/modbus_rtu_frame_classifier_top.sv =====
// Top level of the Modbus RTU frame classifier: configuration registers and
// the front end, record queue and back end. Uses mrfc_pkg, mrfc_front,
// mrfc_fifo and mrfc_back.
//
// Usage: frame bytes enter on the s_ stream, one byte per transaction, with
// s_tlast on the last byte of a frame. One result per frame leaves on the m_
// stream: class and watched slot in m_tuser, length, CRCs and captured values
// in m_tdata. Configuration registers are written on the cfg_ channel, which
// is always ready; write them only while no frame is in flight.
// Throughput is one byte per cycle while s_tready is high. The edge that
// accepts the last byte of a frame puts the frame record in the queue; a
// later pop loads it into the back end's output register, which drives m_tvalid.
// One CRC byte update per cycle in the front end sets the byte rate, and the back
// end classifies one frame per cycle while its output register is free or read.
// When the m_ side stalls, results wait in the output register and up to four
// finished frames wait in the queue; bytes keep flowing until that queue is
// full, then s_tready drops.
// Reset clears the frame state, the captured values and the poll flag, and
// loads the registers with their default values.
module modbus_rtu_frame_classifier_top #(
    parameter int MAX_FRAME   = 256,
    parameter int WATCH_SLOTS = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,    // [7:0] rx_byte
    input  logic            s_tlast,    // frame_end
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [111:0]    m_tdata,    // [8:0] frame_length, [24:9] computed_crc,
                                        // [40:25] received_crc, [104:41] watched_values
    output logic [4:0]      m_tuser,    // [2:0] frame_class, [4:3] watch_index
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    mrfc_pkg::cfg_t         cfg_reg, cfg_next;
    mrfc_pkg::frame_rec_t   push_rec;
    mrfc_pkg::frame_rec_t   pop_rec;
    logic                   push;
    logic                   pop;
    logic                   full;
    logic                   empty;
    logic [2:0]             res_class;
    logic [1:0]             res_widx;
    logic [8:0]             res_length;
    logic [15:0]            res_crc;
    logic [15:0]            res_rx_crc;
    logic [63:0]            res_watched;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mrfc_pkg::CFG_SLAVE_ADDR: cfg_next.slave_addr   = cfg_data[7:0];
                mrfc_pkg::CFG_WATCH_A:    cfg_next.watch_reg[0] = cfg_data;
                mrfc_pkg::CFG_WATCH_B:    cfg_next.watch_reg[1] = cfg_data;
                mrfc_pkg::CFG_WATCH_C:    cfg_next.watch_reg[2] = cfg_data;
                mrfc_pkg::CFG_WATCH_D:    cfg_next.watch_reg[3] = cfg_data;
                mrfc_pkg::CFG_POLL_START: cfg_next.poll_start   = cfg_data;
                mrfc_pkg::CFG_POLL_COUNT: cfg_next.poll_count   = cfg_data[6:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_addr   <= mrfc_pkg::RST_SLAVE_ADDR;
            cfg_reg.watch_reg[0] <= mrfc_pkg::RST_WATCH_A;
            cfg_reg.watch_reg[1] <= mrfc_pkg::RST_WATCH_B;
            cfg_reg.watch_reg[2] <= mrfc_pkg::RST_WATCH_C;
            cfg_reg.watch_reg[3] <= mrfc_pkg::RST_WATCH_D;
            cfg_reg.poll_start   <= mrfc_pkg::RST_POLL_START;
            cfg_reg.poll_count   <= mrfc_pkg::RST_POLL_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mrfc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .full     (full),
        .push     (push),
        .push_rec (push_rec)
    );

    mrfc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (full),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (empty)
    );

    mrfc_back #(
        .WATCH_SLOTS (WATCH_SLOTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .empty       (empty),
        .rec         (pop_rec),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_class   (res_class),
        .out_widx    (res_widx),
        .out_length  (res_length),
        .out_crc     (res_crc),
        .out_rx_crc  (res_rx_crc),
        .out_watched (res_watched)
    );

    assign m_tuser = {res_widx, res_class};
    assign m_tdata = {7'b0, res_watched, res_rx_crc, res_crc, res_length};

endmodule

// ===== rtl/mrfc_front.sv =====
// Front end: takes frame bytes, runs the CRC over the body, holds the trailer
// and header bytes, and pushes one frame record on the last byte. Uses mrfc_pkg.
module mrfc_front #(
    parameter int MAX_FRAME = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    input  logic                    full,
    output logic                    push,
    output mrfc_pkg::frame_rec_t    push_rec
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    logic [15:0]                                crc_reg,  crc_next;
    logic [7:0]                                 td0_reg,  td0_next;
    logic [7:0]                                 td1_reg,  td1_next;
    logic [CNT_W-1:0]                           cnt_reg,  cnt_next;
    logic                                       over_reg, over_next;
    logic [mrfc_pkg::HDR_BYTES-1:0][7:0]        hdr_reg,  hdr_next;

    logic                                       accept;
    logic [15:0]                                crc_upd;
    logic [7:0]                                 td0_upd;
    logic [7:0]                                 td1_upd;
    logic [CNT_W-1:0]                           cnt_upd;
    logic                                       over_upd;
    logic [mrfc_pkg::HDR_BYTES-1:0][7:0]        hdr_upd;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // Frame state after taking this byte.
    always_comb
    begin
        crc_upd  = (cnt_reg >= CNT_W'(2)) ? mrfc_pkg::crc_byte(crc_reg, td0_reg) : crc_reg;
        td0_upd  = td1_reg;
        td1_upd  = in_byte;
        hdr_upd  = hdr_reg;
        if (cnt_reg < CNT_W'(mrfc_pkg::HDR_BYTES))
            hdr_upd[cnt_reg[2:0]] = in_byte;
        cnt_upd  = (cnt_reg < CNT_W'(MAX_FRAME)) ? cnt_reg + CNT_W'(1) : cnt_reg;
        over_upd = over_reg || (cnt_reg == CNT_W'(MAX_FRAME));
    end

    always_comb
    begin
        push               = accept && in_last;
        push_rec.overflow  = over_upd;
        push_rec.too_short = cnt_upd < CNT_W'(3);
        push_rec.length    = 9'(cnt_upd);
        push_rec.crc       = crc_upd;
        push_rec.rx_crc    = {td1_upd, td0_upd};
        push_rec.hdr       = hdr_upd;

        crc_next  = crc_reg;
        td0_next  = td0_reg;
        td1_next  = td1_reg;
        cnt_next  = cnt_reg;
        over_next = over_reg;
        hdr_next  = hdr_reg;
        if (accept)
        begin
            if (in_last)
            begin
                crc_next  = mrfc_pkg::CRC_INIT;
                td0_next  = '0;
                td1_next  = '0;
                cnt_next  = '0;
                over_next = 1'b0;
                hdr_next  = '0;
            end
            else
            begin
                crc_next  = crc_upd;
                td0_next  = td0_upd;
                td1_next  = td1_upd;
                cnt_next  = cnt_upd;
                over_next = over_upd;
                hdr_next  = hdr_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= mrfc_pkg::CRC_INIT;
            td0_reg  <= '0;
            td1_reg  <= '0;
            cnt_reg  <= '0;
            over_reg <= 1'b0;
            hdr_reg  <= '0;
        end
        else
        begin
            crc_reg  <= crc_next;
            td0_reg  <= td0_next;
            td1_reg  <= td1_next;
            cnt_reg  <= cnt_next;
            over_reg <= over_next;
            hdr_reg  <= hdr_next;
        end
    end

endmodule

// ===== rtl/mrfc_fifo.sv =====
// Short queue of finished frame records between the front and back ends.
// Uses mrfc_pkg and the assertion macros of the defines header.
`include "modbus_rtu_frame_classifier_top_defines.svh"
module mrfc_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mrfc_pkg::frame_rec_t    push_rec,
    output logic                    full,
    input  logic                    pop,
    output mrfc_pkg::frame_rec_t    pop_rec,
    output logic                    empty
);

    localparam int DEPTH = mrfc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrfc_pkg::frame_rec_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg,  count_next;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign pop_rec = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The count is not yet defined before the first reset edge.
    `MRFC_ASSERT_ALWAYS(a_count_bound, clk, !rst_n || (count_reg <= CNT_W'(DEPTH)),
                        "queue count beyond depth")
    `MRFC_ASSERT(a_no_push_full, clk, rst_n, push |-> !full, "push into a full queue")
    `MRFC_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> !empty, "pop from an empty queue")
    `MRFC_ASSERT(a_count_inc, clk, rst_n,
                 (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)),
                 "queue count did not advance on push")

endmodule

// ===== rtl/mrfc_back.sv =====
// Back end: classifies each frame record, updates the captured values and the
// poll flag, and holds the result in an output register. Uses mrfc_pkg.
module mrfc_back #(
    parameter int WATCH_SLOTS = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mrfc_pkg::cfg_t          cfg,
    input  logic                    empty,
    input  mrfc_pkg::frame_rec_t    rec,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              out_class,
    output logic [1:0]              out_widx,
    output logic [8:0]              out_length,
    output logic [15:0]             out_crc,
    output logic [15:0]             out_rx_crc,
    output logic [63:0]             out_watched
);

    logic                                       valid_reg,  valid_next;
    mrfc_pkg::class_t                           class_reg,  class_next;
    logic [1:0]                                 widx_reg,   widx_next;
    logic [8:0]                                 len_reg,    len_next;
    logic [15:0]                                crc_reg,    crc_next;
    logic [15:0]                                rxcrc_reg,  rxcrc_next;
    logic [mrfc_pkg::WATCH_MAX-1:0][15:0]       cap_reg,    cap_next;
    logic                                       pend_reg,   pend_next;

    logic [15:0]        reg_num;
    logic               addr_ok;
    logic               write_ok;
    logic               hit;
    logic [1:0]         hit_idx;
    logic               poll_req;
    logic               poll_rsp;
    logic [7:0]         rsp_bytes;
    mrfc_pkg::class_t   cls;

    assign pop = !empty && (!valid_reg || out_ready);

    always_comb
    begin
        reg_num   = {rec.hdr[2], rec.hdr[3]};
        addr_ok   = rec.hdr[0] == cfg.slave_addr;
        write_ok  = addr_ok && (rec.hdr[1] == mrfc_pkg::FUNC_WRITE_SINGLE);
        rsp_bytes = {cfg.poll_count, 1'b0};
        hit       = 1'b0;
        hit_idx   = '0;
        // First watched slot that matches wins.
        for (int s = 0; s < mrfc_pkg::WATCH_MAX; s++) begin
            if (!hit && (s < WATCH_SLOTS) && write_ok && (reg_num == cfg.watch_reg[s]))
            begin
                hit     = 1'b1;
                hit_idx = 2'(s);
            end
        end
        poll_req = addr_ok && (rec.hdr[1] == mrfc_pkg::FUNC_READ_HOLDING)
                   && (reg_num == cfg.poll_start) && (rec.hdr[4] == 8'h00)
                   && (rec.hdr[5] == {1'b0, cfg.poll_count});
        poll_rsp = pend_reg && addr_ok && (rec.hdr[1] == mrfc_pkg::FUNC_READ_HOLDING)
                   && (rec.hdr[2] == rsp_bytes);

        priority if (rec.overflow)
            cls = mrfc_pkg::CLASS_OVERFLOW;
        else if (rec.too_short)
            cls = mrfc_pkg::CLASS_SHORT;
        else if (rec.crc != rec.rx_crc)
            cls = mrfc_pkg::CLASS_BAD_CRC;
        else if (hit)
            cls = mrfc_pkg::CLASS_WATCHED;
        else if (poll_req)
            cls = mrfc_pkg::CLASS_POLL_REQ;
        else if (poll_rsp)
            cls = mrfc_pkg::CLASS_POLL_RSP;
        else
            cls = mrfc_pkg::CLASS_OTHER;
    end

    always_comb
    begin
        valid_next = valid_reg;
        class_next = class_reg;
        widx_next  = widx_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        rxcrc_next = rxcrc_reg;
        cap_next   = cap_reg;
        pend_next  = pend_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            class_next = cls;
            widx_next  = (cls == mrfc_pkg::CLASS_WATCHED) ? hit_idx : 2'd0;
            len_next   = rec.length;
            crc_next   = rec.crc;
            rxcrc_next = rec.rx_crc;
            if (cls == mrfc_pkg::CLASS_WATCHED)
                cap_next[hit_idx] = {rec.hdr[4], rec.hdr[5]};
            if (cls == mrfc_pkg::CLASS_POLL_REQ)
                pend_next = 1'b1;
            else if (cls == mrfc_pkg::CLASS_POLL_RSP)
                pend_next = 1'b0;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cap_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            cap_reg   <= cap_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
        widx_reg  <= widx_next;
        len_reg   <= len_next;
        crc_reg   <= crc_next;
        rxcrc_reg <= rxcrc_next;
    end

    // Captured values only change when a new result is loaded, so they can
    // drive the output directly.
    assign out_valid   = valid_reg;
    assign out_class   = class_reg;
    assign out_widx    = widx_reg;
    assign out_length  = len_reg;
    assign out_crc     = crc_reg;
    assign out_rx_crc  = rxcrc_reg;
    assign out_watched = {cap_reg[0], cap_reg[1], cap_reg[2], cap_reg[3]};

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the Modbus RTU frame classifier: streams frames
// in bursts, predicts every per-frame result and compares it field by field.
// Depends on mrfc_pkg and modbus_rtu_frame_classifier_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAME   = 256;
    localparam int WATCH_SLOTS = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 80;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef logic [7:0] byte_list_t[$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tx_byte_t;

    typedef struct packed {
        mrfc_pkg::class_t cls;
        logic [1:0]       slot;
        logic [8:0]       length;
        logic [15:0]      crc_calc;
        logic [15:0]      crc_rx;
        logic [63:0]      captured;
    } frame_result_t;

    typedef enum int {FK_WATCH, FK_POLL_REQ, FK_POLL_RSP, FK_OTHER, FK_STUB} frame_kind_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [7:0]     s_tdata = '0;    // [7:0] rx_byte
    logic           s_tlast = 1'b0;  // frame_end
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [111:0]   m_tdata;         // [8:0] frame_length, [24:9] computed_crc,
                                     // [40:25] received_crc, [104:41] watched_values
    logic [4:0]     m_tuser;         // [2:0] frame_class, [4:3] watch_index
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [2:0]     cfg_index = '0;
    logic [15:0]    cfg_data = '0;

    modbus_rtu_frame_classifier_top #(
        .MAX_FRAME   (MAX_FRAME),
        .WATCH_SLOTS (WATCH_SLOTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copy, as the block should hold it.
    logic [7:0]  cf_addr = mrfc_pkg::RST_SLAVE_ADDR;
    logic [15:0] cf_watch [4] = '{mrfc_pkg::RST_WATCH_A, mrfc_pkg::RST_WATCH_B,
                                  mrfc_pkg::RST_WATCH_C, mrfc_pkg::RST_WATCH_D};
    logic [15:0] cf_pstart = mrfc_pkg::RST_POLL_START;
    logic [6:0]  cf_pcount = mrfc_pkg::RST_POLL_COUNT;

    // Frame state of the predictor.
    logic [15:0] fr_crc = mrfc_pkg::CRC_INIT;
    logic [7:0]  fr_trail [2] = '{8'h00, 8'h00};
    int          fr_count = 0;
    logic        fr_over = 1'b0;
    logic [7:0]  fr_hdr [mrfc_pkg::HDR_BYTES] = '{default: 8'h00};
    logic [15:0] fr_cap [4] = '{default: 16'h0000};
    logic        fr_poll_armed = 1'b0;

    frame_result_t predicted_frames[$];
    tx_byte_t      tx_queue[$];
    int            mismatches = 0;
    int            cycle_count = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            stall_mode = 0;
    int            stall_tick = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc16_update(logic [15:0] crc_in, logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ d[i];
            r = r >> 1;
            if (fb)
                r = r ^ mrfc_pkg::CRC_POLY;
        end
        return r;
    endfunction

    // Advances the predicted frame state by one accepted byte and, on the
    // last byte, queues the result the block must report for that frame.
    function automatic void classify_byte(logic [7:0] b, logic last);
        frame_result_t res;
        logic [15:0]   rx_crc;
        logic [15:0]   wreg;
        logic          hit;
        logic          addr_ok;
        if (fr_count >= 2)
            fr_crc = crc16_update(fr_crc, fr_trail[0]);
        fr_trail[0] = fr_trail[1];
        fr_trail[1] = b;
        if (fr_count < mrfc_pkg::HDR_BYTES)
            fr_hdr[fr_count] = b;
        if (fr_count < MAX_FRAME)
            fr_count++;
        else
            fr_over = 1'b1;
        if (!last)
            return;

        rx_crc = {fr_trail[1], fr_trail[0]};
        wreg = {fr_hdr[2], fr_hdr[3]};
        addr_ok = (fr_hdr[0] == cf_addr);
        res.slot = 2'd0;
        hit = 1'b0;
        if (fr_over)
            res.cls = mrfc_pkg::CLASS_OVERFLOW;
        else if (fr_count < 3)
            res.cls = mrfc_pkg::CLASS_SHORT;
        else if (fr_crc != rx_crc)
            res.cls = mrfc_pkg::CLASS_BAD_CRC;
        else begin
            res.cls = mrfc_pkg::CLASS_OTHER;
            if (addr_ok && fr_hdr[1] == mrfc_pkg::FUNC_WRITE_SINGLE) begin
                for (int s = 0; s < WATCH_SLOTS; s++) begin
                    if (!hit && wreg == cf_watch[s]) begin
                        fr_cap[s] = {fr_hdr[4], fr_hdr[5]};
                        res.cls = mrfc_pkg::CLASS_WATCHED;
                        res.slot = 2'(s);
                        hit = 1'b1;
                    end
                end
            end
            if (!hit) begin
                if (addr_ok && fr_hdr[1] == mrfc_pkg::FUNC_READ_HOLDING &&
                    wreg == cf_pstart &&
                    fr_hdr[4] == 8'h00 && fr_hdr[5] == {1'b0, cf_pcount}) begin
                    res.cls = mrfc_pkg::CLASS_POLL_REQ;
                    fr_poll_armed = 1'b1;
                end else if (fr_poll_armed && addr_ok &&
                             fr_hdr[1] == mrfc_pkg::FUNC_READ_HOLDING &&
                             fr_hdr[2] == {cf_pcount, 1'b0}) begin
                    res.cls = mrfc_pkg::CLASS_POLL_RSP;
                    fr_poll_armed = 1'b0;
                end
            end
        end
        res.length = 9'(fr_count);
        res.crc_calc = fr_crc;
        res.crc_rx = rx_crc;
        res.captured = {fr_cap[0], fr_cap[1], fr_cap[2], fr_cap[3]};
        predicted_frames.push_back(res);

        fr_crc = mrfc_pkg::CRC_INIT;
        fr_trail[0] = 8'h00;
        fr_trail[1] = 8'h00;
        fr_count = 0;
        fr_over = 1'b0;
        for (int i = 0; i < mrfc_pkg::HDR_BYTES; i++)
            fr_hdr[i] = 8'h00;
    endfunction

    task automatic send_raw(input byte_list_t bytes);
        tx_byte_t t;
        foreach (bytes[i]) begin
            t.data = bytes[i];
            t.last = (i == bytes.size() - 1);
            tx_queue.push_back(t);
        end
    endtask

    // Appends the CRC trailer, low byte first; a corrupted frame gets one
    // flipped bit, which the CRC always detects.
    task automatic send_frame(input byte_list_t body, input bit corrupt);
        logic [15:0] c;
        byte_list_t  all;
        int          pos;
        c = mrfc_pkg::CRC_INIT;
        foreach (body[i])
            c = crc16_update(c, body[i]);
        all = body;
        all.push_back(c[7:0]);
        all.push_back(c[15:8]);
        if (corrupt) begin
            pos = $urandom_range(0, all.size() - 1);
            all[pos] = all[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        send_raw(all);
    endtask

    function automatic logic [7:0] pick_addr();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : cf_addr;
    endfunction

    function automatic logic [7:0] pick_func(logic [7:0] f);
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : f;
    endfunction

    task automatic make_body(input frame_kind_t kind, output byte_list_t body);
        logic [15:0] r;
        int          extra;
        body.delete();
        case (kind)
            FK_WATCH: begin
                r = ($urandom_range(0, 6) == 0) ? 16'($urandom) : cf_watch[$urandom_range(0, 3)];
                body.push_back(pick_addr());
                body.push_back(pick_func(mrfc_pkg::FUNC_WRITE_SINGLE));
                body.push_back(r[15:8]);
                body.push_back(r[7:0]);
                body.push_back(8'($urandom));
                body.push_back(8'($urandom));
                extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            end
            FK_POLL_REQ: begin
                r = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cf_pstart;
                body.push_back(pick_addr());
                body.push_back(pick_func(mrfc_pkg::FUNC_READ_HOLDING));
                body.push_back(r[15:8]);
                body.push_back(r[7:0]);
                body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
                body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : {1'b0, cf_pcount});
                extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            end
            FK_POLL_RSP: begin
                body.push_back(pick_addr());
                body.push_back(pick_func(mrfc_pkg::FUNC_READ_HOLDING));
                body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : {cf_pcount, 1'b0});
                extra = $urandom_range(0, 6);
            end
            FK_STUB: begin
                // Frames of three or four bytes leave header positions unreceived.
                body.push_back(pick_addr());
                extra = 0;
                if ($urandom_range(0, 1) == 1)
                    body.push_back($urandom_range(0, 1) ? mrfc_pkg::FUNC_WRITE_SINGLE
                                                        : mrfc_pkg::FUNC_READ_HOLDING);
            end
            default: begin
                extra = $urandom_range(1, 12);
                if ($urandom_range(0, 1) == 1) begin
                    body.push_back(cf_addr);
                    extra--;
                end
            end
        endcase
        repeat (extra)
            body.push_back(8'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mrfc_pkg::CFG_SLAVE_ADDR: cf_addr = val[7:0];
            mrfc_pkg::CFG_WATCH_A:    cf_watch[0] = val;
            mrfc_pkg::CFG_WATCH_B:    cf_watch[1] = val;
            mrfc_pkg::CFG_WATCH_C:    cf_watch[2] = val;
            mrfc_pkg::CFG_WATCH_D:    cf_watch[3] = val;
            mrfc_pkg::CFG_POLL_START: cf_pstart = val;
            mrfc_pkg::CFG_POLL_COUNT: cf_pcount = val[6:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Unused upper bits of the narrow registers carry noise on purpose.
    task automatic set_config(input logic [7:0] addr, input logic [15:0] wa,
                              input logic [15:0] wb, input logic [15:0] wc,
                              input logic [15:0] wd, input logic [15:0] ps,
                              input logic [6:0] pc);
        write_reg(mrfc_pkg::CFG_SLAVE_ADDR, {8'($urandom), addr});
        write_reg(mrfc_pkg::CFG_WATCH_A, wa);
        write_reg(mrfc_pkg::CFG_WATCH_B, wb);
        write_reg(mrfc_pkg::CFG_WATCH_C, wc);
        write_reg(mrfc_pkg::CFG_WATCH_D, wd);
        write_reg(mrfc_pkg::CFG_POLL_START, ps);
        write_reg(mrfc_pkg::CFG_POLL_COUNT, {9'($urandom), pc});
    endtask

    // Holds off until every queued byte is taken and every frame reported,
    // then lets the pipeline settle.
    task automatic wait_idle();
        while (tx_queue.size() != 0 || s_tvalid || predicted_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n) begin : byte_driver
        tx_byte_t nxt;
        logic     take;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                classify_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                take = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (tx_queue.size() != 0) begin
                    nxt = tx_queue.pop_front();
                    take = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                s_tvalid <= take;
                if (take) begin
                    s_tdata <= nxt.data;
                    s_tlast <= nxt.last;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : result_stall
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_tick = 0;
            stall_mode = 0;
        end else begin
            stall_tick++;
            if (stall_tick % 50 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) < 7);
                2:       m_tready <= ($urandom_range(0, 9) < 2);
                default: m_tready <= (stall_tick % 5 == 0);
            endcase
        end
    end

    always @(posedge clk) begin : result_check
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (predicted_frames.size() == 0) begin
                $error("frame result transaction with no frame pending");
                mismatches++;
            end else begin
                want = predicted_frames.pop_front();
                if (m_tuser[2:0] !== want.cls) begin
                    $error("frame_class: expected %0d, got %0d", want.cls, m_tuser[2:0]);
                    mismatches++;
                end
                if (m_tuser[4:3] !== want.slot) begin
                    $error("watch_index: expected %0d, got %0d", want.slot, m_tuser[4:3]);
                    mismatches++;
                end
                if (m_tdata[8:0] !== want.length) begin
                    $error("frame_length: expected %0d, got %0d", want.length, m_tdata[8:0]);
                    mismatches++;
                end
                if (m_tdata[24:9] !== want.crc_calc) begin
                    $error("computed_crc: expected %h, got %h", want.crc_calc, m_tdata[24:9]);
                    mismatches++;
                end
                if (m_tdata[40:25] !== want.crc_rx) begin
                    $error("received_crc: expected %h, got %h", want.crc_rx, m_tdata[40:25]);
                    mismatches++;
                end
                if (m_tdata[104:41] !== want.captured) begin
                    $error("watched_values: expected %h, got %h", want.captured,
                           m_tdata[104:41]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        byte_list_t  body;
        frame_kind_t kind;
        int          pick;
        int          phase_start;
        logic [15:0] w [4];

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset settings: both short lengths,
        // the smallest good frame, and one of each recognized class.
        body = '{8'h00};
        send_raw(body);
        body = '{8'hFF, 8'hFF};
        send_raw(body);
        body = '{8'hA5};
        send_frame(body, 1'b0);
        body = '{8'h01, mrfc_pkg::FUNC_WRITE_SINGLE, 8'h0F, 8'h9F, 8'h12, 8'h34};
        send_frame(body, 1'b0);
        body = '{8'h01, mrfc_pkg::FUNC_READ_HOLDING, 8'h08, 8'h33, 8'h00, 8'h28};
        send_frame(body, 1'b0);
        body = '{8'h01, mrfc_pkg::FUNC_READ_HOLDING, 8'h50};
        send_frame(body, 1'b0);
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(8'h00, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 7'd1);
                1: begin
                    set_config(8'hFF, 16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFE, 16'hFFFF, 7'd125);
                    write_reg(CFG_UNUSED, 16'($urandom));
                end
                default: begin
                    foreach (w[i])
                        w[i] = 16'($urandom);
                    // Now and then two slots watch the same register.
                    if ($urandom_range(0, 1) == 1)
                        w[$urandom_range(1, 3)] = w[0];
                    set_config(8'($urandom), w[0], w[1], w[2], w[3], 16'($urandom),
                               7'($urandom_range(1, 125)));
                end
            endcase

            if (phase == 1) begin
                // A watched write padded to exactly the maximum length.
                make_body(FK_WATCH, body);
                while (body.size() < MAX_FRAME - 2)
                    body.push_back(8'($urandom));
                send_frame(body, 1'b0);
            end
            if (phase == 3) begin
                body.delete();
                repeat ($urandom_range(MAX_FRAME - 1, MAX_FRAME + 2))
                    body.push_back(8'($urandom));
                send_frame(body, 1'b0);
            end

            phase_start = tx_queue.size();
            while (tx_queue.size() - phase_start < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    body.delete();
                    repeat ($urandom_range(1, 2))
                        body.push_back(8'($urandom));
                    send_raw(body);
                end else begin
                    if (pick < 31)
                        kind = FK_WATCH;
                    else if (pick < 46)
                        kind = FK_POLL_REQ;
                    else if (pick < 61)
                        kind = FK_POLL_RSP;
                    else if (pick < 80)
                        kind = FK_OTHER;
                    else if (pick < 88)
                        kind = FK_STUB;
                    else
                        kind = frame_kind_t'($urandom_range(0, 4));
                    make_body(kind, body);
                    send_frame(body, pick >= 88);
                    if (kind == FK_POLL_REQ && pick < 88 && $urandom_range(0, 9) < 6) begin
                        make_body(FK_POLL_RSP, body);
                        send_frame(body, 1'b0);
                    end
                end
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (predicted_frames.size() != 0) begin
            $error("%0d frame results never arrived", predicted_frames.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== modbus_rtu_frame_classifier_top.f =====
+incdir+rtl
rtl/mrfc_pkg.sv
rtl/mrfc_front.sv
rtl/mrfc_fifo.sv
rtl/mrfc_back.sv
rtl/modbus_rtu_frame_classifier_top.sv
tb/sv/tb.sv
